[rtl/heliostat_step_planner_assert.svh]
// assertion helpers shared by the planner modules
// both expect clk and rst_n in the enclosing scope
`ifndef HELIOSTAT_STEP_PLANNER_ASSERT_SVH
`define HELIOSTAT_STEP_PLANNER_ASSERT_SVH

// same-cycle implication
`define HSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsp check failed");

// next-cycle implication
`define HSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsp check failed");

`endif

[rtl/hsp_pkg.sv]
package hsp_pkg;

    // fixed point fraction bits of all internal angles
    localparam int FRAC_BITS = 8;

    // field widths
    localparam int TGT_W   = 10;
    localparam int ZEN_W   = 8;
    localparam int AZI_W   = 9;
    localparam int STEP_W  = 16;
    localparam int STEPS_W = 18;
    localparam int MIR_W   = 19;
    localparam int POS_W   = 20;

    // derived widths
    localparam int ANG2_W = 12;
    localparam int EXT_W  = ANG2_W + FRAC_BITS;
    localparam int DIFF_W = POS_W + 1;
    localparam int MAG_W  = DIFF_W;
    localparam int WIDE_W = POS_W + 2;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    // stream and config widths
    localparam int IN_BITS     = ZEN_W + 1 + AZI_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * (STEPS_W + 1) + 2 * MIR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STEP_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ZENITH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_AZIMUTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORTH_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 2'd3;

    // command codes
    localparam logic CMD_TRACK = 1'b0;
    localparam logic CMD_HOME  = 1'b1;

    // register reset values
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(461);

    // fixed point constants
    localparam logic [MAG_W-1:0] STEPS_MAX = MAG_W'((2 ** STEPS_W) - 1);
    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'((2 ** (POS_W - 1)) - 1);
    localparam logic signed [POS_W-1:0] HOME_AZ = POS_W'(-90 * (2 ** FRAC_BITS));
    localparam logic signed [DIFF_W-1:0] WRAP_LIMIT = DIFF_W'(100 * (2 ** FRAC_BITS));
    localparam logic signed [WIDE_W-1:0] WRAP_ADD = WIDE_W'(180 * (2 ** FRAC_BITS));

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/heliostat_step_planner.sv]
// a track beat runs through the angle, prep, divide and finish states; a home beat skips prep and divide
// a new beat is taken only in the idle state, after the previous one has reached the output register
// the two bit-serial dividers run in lockstep, one quotient bit per cycle over 21 bits
// a finished result waits in the output register while the next beat is taken
// reset (rst_n, async, active low) restores register defaults and clears motor positions
`include "heliostat_step_planner_assert.svh"

module heliostat_step_planner (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hsp_pkg::CFG_DATA_W-1:0]      cfg_data,
    // sun samples
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hsp_pkg::IN_TDATA_W-1:0]      s_tdata,  // zenith_deg, zenith_negative, azimuth_deg
    input  logic                                s_tuser,  // command
    // step plans
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // zenith_steps, zenith_up, azimuth_steps, azimuth_up, mirror_zenith, mirror_azimuth
    output logic [hsp_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import hsp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ANGLE  = 5'b00010,
        ST_PREP   = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // config registers
    logic signed [TGT_W-1:0] tz_reg;
    logic signed [TGT_W-1:0] ta_reg;
    logic                    north_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_eff;

    // latched sample
    logic             cmd_reg;
    logic [ZEN_W-1:0] zen_reg;
    logic             below_reg;
    logic [AZI_W-1:0] azi_reg;

    // angles and positions
    logic signed [MIR_W-1:0] mz_c;
    logic signed [MIR_W-1:0] ma_c;
    logic signed [MIR_W-1:0] mz_reg;
    logic signed [MIR_W-1:0] ma_reg;
    logic signed [MIR_W-1:0] last_ma_reg;
    logic signed [POS_W-1:0] zpos_reg;
    logic signed [POS_W-1:0] zpos_next;
    logic signed [POS_W-1:0] apos_reg;
    logic signed [POS_W-1:0] apos_next;

    // motor distances
    logic signed [DIFF_W-1:0] zdiff;
    logic signed [DIFF_W-1:0] adiff;
    logic signed [DIFF_W-1:0] wrap_diff;
    logic signed [WIDE_W-1:0] wrap_sum;
    logic                     wrap_hit;
    logic [MAG_W-1:0]         zmag_c;
    logic [MAG_W-1:0]         amag_c;
    logic [MAG_W-1:0]         zmag_reg;
    logic [MAG_W-1:0]         amag_reg;
    logic                     zup_reg;
    logic                     aup_reg;

    // dividers
    logic              div_start;
    logic [MAG_W-1:0]  zquo;
    logic [MAG_W-1:0]  aquo;
    logic [STEP_W-1:0] zrem;
    logic [STEP_W-1:0] arem;
    div_stat_t         zstat;
    div_stat_t         astat;

    // result
    logic [STEPS_W-1:0]     zsteps;
    logic [STEPS_W-1:0]     asteps;
    logic [MAG_W-1:0]       zdelta;
    logic [MAG_W-1:0]       adelta;
    logic                   out_load;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] out_next;

    // steps from quotient, zero below horizon, saturated
    function automatic logic [STEPS_W-1:0] steps_of(input logic [MAG_W-1:0] q,
                                                    input logic below);
        begin
            if (below)
            begin
                steps_of = '0;
            end
            else if (q > STEPS_MAX)
            begin
                steps_of = STEPS_MAX[STEPS_W-1:0];
            end
            else
            begin
                steps_of = q[STEPS_W-1:0];
            end
        end
    endfunction

    // distance moved: steps times step size, never more than the magnitude
    function automatic logic [MAG_W-1:0] delta_of(input logic [MAG_W-1:0] q,
                                                  input logic [STEP_W-1:0] r,
                                                  input logic [MAG_W-1:0] mag,
                                                  input logic [STEP_W-1:0] dsr,
                                                  input logic below);
        logic [STEP_W+STEPS_W-1:0] sat;
        begin
            sat = ((STEP_W + STEPS_W)'(dsr) << STEPS_W) - (STEP_W + STEPS_W)'(dsr);
            if (below)
            begin
                delta_of = '0;
            end
            else if (q > STEPS_MAX)
            begin
                delta_of = sat[MAG_W-1:0];
            end
            else
            begin
                delta_of = mag - MAG_W'(r);
            end
        end
    endfunction

    // position moved toward the mirror
    function automatic logic signed [POS_W-1:0] move_of(input logic signed [POS_W-1:0] pos,
                                                        input logic [MAG_W-1:0] dlt,
                                                        input logic up);
        logic signed [WIDE_W-1:0] p;
        logic signed [WIDE_W-1:0] d;
        logic signed [WIDE_W-1:0] s;
        begin
            p = WIDE_W'(pos);
            d = signed'(WIDE_W'(dlt));
            s = up ? p + d : p - d;
            move_of = s[POS_W-1:0];
        end
    endfunction

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg    <= '0;
            ta_reg    <= '0;
            north_reg <= 1'b1;
            step_reg  <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_ZENITH:  tz_reg    <= cfg_data[TGT_W-1:0];
                REG_TARGET_AZIMUTH: ta_reg    <= cfg_data[TGT_W-1:0];
                REG_NORTH_MODE:     north_reg <= cfg_data[0];
                REG_STEP_SIZE:      step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // mirror angle
    hsp_mirror u_mirror (
        .north_mode      (north_reg),
        .target_zenith   (tz_reg),
        .target_azimuth  (ta_reg),
        .zenith_deg      (zen_reg),
        .zenith_negative (below_reg),
        .azimuth_deg     (azi_reg),
        .last_azimuth    (last_ma_reg),
        .mirror_zenith   (mz_c),
        .mirror_azimuth  (ma_c)
    );

    // azimuth wrap correction
    assign wrap_diff = DIFF_W'(ma_c) - DIFF_W'(apos_reg);
    assign wrap_hit  = (wrap_diff > WRAP_LIMIT) && (apos_reg > 0);
    assign wrap_sum  = WIDE_W'(apos_reg) + WRAP_ADD;

    // distance to the mirror
    assign zdiff  = DIFF_W'(mz_reg) - DIFF_W'(zpos_reg);
    assign adiff  = DIFF_W'(ma_reg) - DIFF_W'(apos_reg);
    assign zmag_c = zdiff[DIFF_W-1] ? MAG_W'(-zdiff) : MAG_W'(zdiff);
    assign amag_c = adiff[DIFF_W-1] ? MAG_W'(-adiff) : MAG_W'(adiff);

    assign div_start = (state_reg == ST_PREP);

    hsp_div u_zdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (zmag_c),
        .divisor   (step_eff),
        .quotient  (zquo),
        .remainder (zrem),
        .stat      (zstat)
    );

    hsp_div u_adiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (amag_c),
        .divisor   (step_eff),
        .quotient  (aquo),
        .remainder (arem),
        .stat      (astat)
    );

    // step counts and moves
    assign zsteps = steps_of(zquo, below_reg);
    assign asteps = steps_of(aquo, below_reg);
    assign zdelta = delta_of(zquo, zrem, zmag_reg, step_eff, below_reg);
    assign adelta = delta_of(aquo, arem, amag_reg, step_eff, below_reg);

    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // result beat
    always_comb
    begin
        if (cmd_reg == CMD_HOME)
        begin
            out_next = '0;
        end
        else
        begin
            out_next = OUT_TDATA_W'({ma_reg, mz_reg, aup_reg, asteps, zup_reg, zsteps});
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                state_next = (cmd_reg == CMD_HOME) ? ST_FINISH : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (zstat.done && astat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // motor positions
    always_comb
    begin
        zpos_next = zpos_reg;
        apos_next = apos_reg;
        if (state_reg == ST_ANGLE && cmd_reg == CMD_TRACK && wrap_hit)
        begin
            apos_next = (wrap_sum > WIDE_W'(POS_MAX)) ? POS_MAX : wrap_sum[POS_W-1:0];
        end
        else if (out_load)
        begin
            if (cmd_reg == CMD_HOME)
            begin
                zpos_next = '0;
                apos_next = HOME_AZ;
            end
            else
            begin
                zpos_next = move_of(zpos_reg, zdelta, zup_reg);
                apos_next = move_of(apos_reg, adelta, aup_reg);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            zpos_reg     <= '0;
            apos_reg     <= '0;
            last_ma_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            zpos_reg  <= zpos_next;
            apos_reg  <= apos_next;
            if (state_reg == ST_ANGLE && cmd_reg == CMD_TRACK)
            begin
                last_ma_reg <= ma_c;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tuser;
            zen_reg   <= s_tdata[ZEN_W-1:0];
            below_reg <= s_tdata[ZEN_W];
            azi_reg   <= s_tdata[ZEN_W+AZI_W:ZEN_W+1];
        end
        if (state_reg == ST_ANGLE)
        begin
            mz_reg <= mz_c;
            ma_reg <= ma_c;
        end
        if (state_reg == ST_PREP)
        begin
            zmag_reg <= zmag_c;
            amag_reg <= amag_c;
            zup_reg  <= !zdiff[DIFF_W-1];
            aup_reg  <= !adiff[DIFF_W-1];
        end
        if (out_load)
        begin
            m_tdata_reg <= out_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `HSP_ASSERT_NOW(a_div_lockstep, state_reg == ST_DIVIDE, zstat.done == astat.done)
    `HSP_ASSERT_NEXT(a_home_positions, out_load && cmd_reg == CMD_HOME, zpos_reg == '0 && apos_reg == HOME_AZ)
    `HSP_ASSERT_NOW(a_below_no_motion, out_load && cmd_reg == CMD_TRACK && below_reg, zpos_next == zpos_reg && apos_next == apos_reg)

endmodule

[rtl/hsp_mirror.sv]
module hsp_mirror (
    input  logic                                north_mode,
    input  logic signed [hsp_pkg::TGT_W-1:0]    target_zenith,
    input  logic signed [hsp_pkg::TGT_W-1:0]    target_azimuth,
    input  logic        [hsp_pkg::ZEN_W-1:0]    zenith_deg,
    input  logic                                zenith_negative,
    input  logic        [hsp_pkg::AZI_W-1:0]    azimuth_deg,
    input  logic signed [hsp_pkg::MIR_W-1:0]    last_azimuth,
    output logic signed [hsp_pkg::MIR_W-1:0]    mirror_zenith,
    output logic signed [hsp_pkg::MIR_W-1:0]    mirror_azimuth
);
    import hsp_pkg::*;

    localparam logic signed [ANG2_W-1:0] D180 = ANG2_W'(180);
    localparam logic signed [ANG2_W-1:0] D360 = ANG2_W'(360);
    localparam logic signed [EXT_W-1:0] MIR_HI = EXT_W'((2 ** (MIR_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] MIR_LO = -EXT_W'(2 ** (MIR_W - 1));

    logic signed [ANG2_W-1:0] zmag;
    logic signed [ANG2_W-1:0] z;
    logic signed [ANG2_W-1:0] a;
    logic signed [ANG2_W-1:0] tz;
    logic signed [ANG2_W-1:0] ta;
    logic signed [ANG2_W-1:0] mz2;
    logic signed [ANG2_W-1:0] ma2;
    logic                     hit;

    // double angle to fixed point, saturated to mirror width
    function automatic logic signed [MIR_W-1:0] to_fixed(input logic signed [ANG2_W-1:0] v2);
        logic signed [EXT_W-1:0] x;
        begin
            x = EXT_W'(v2) <<< (FRAC_BITS - 1);
            if (x > MIR_HI)
            begin
                to_fixed = MIR_HI[MIR_W-1:0];
            end
            else if (x < MIR_LO)
            begin
                to_fixed = MIR_LO[MIR_W-1:0];
            end
            else
            begin
                to_fixed = x[MIR_W-1:0];
            end
        end
    endfunction

    // operands at a common width
    assign zmag = ANG2_W'({1'b0, zenith_deg});
    assign z    = zenith_negative ? -zmag : zmag;
    assign a    = ANG2_W'({1'b0, azimuth_deg});
    assign tz   = ANG2_W'(target_zenith);
    assign ta   = ANG2_W'(target_azimuth);

    // bisector cases, twice the angle in whole degrees
    always_comb
    begin
        ma2 = '0;
        hit = 1'b1;
        if (north_mode)
        begin
            mz2 = z + tz;
            priority if ((a >= D180 && D360 - a >= ta) || (a > D180 && D360 - a < ta))
            begin
                ma2 = D360 + ta - a;
            end
            else if ((a < D180 && a < ta) || (a <= D180 && a >= ta))
            begin
                ma2 = ta + a;
            end
            else
            begin
                hit = 1'b0;
            end
        end
        else
        begin
            mz2 = D180 - z + tz;
            priority if (a > D180 && ta <= 0)
            begin
                ma2 = a + ta - D180;
            end
            else if (a < D180 && ta < 0)
            begin
                ma2 = D180 - a - ta;
            end
            else if (a > D180 && ta > 0)
            begin
                ma2 = a - ta - D180;
            end
            else if (a < D180 && ta >= 0)
            begin
                ma2 = D180 - a + ta;
            end
            else
            begin
                hit = 1'b0;
            end
        end
    end

    // no matching case keeps the previous azimuth
    assign mirror_zenith  = to_fixed(mz2);
    assign mirror_azimuth = hit ? to_fixed(ma2) : last_azimuth;

endmodule

[rtl/hsp_div.sv]
`include "heliostat_step_planner_assert.svh"

module hsp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [hsp_pkg::MAG_W-1:0]       dividend,
    input  logic [hsp_pkg::STEP_W-1:0]      divisor,
    output logic [hsp_pkg::MAG_W-1:0]       quotient,
    output logic [hsp_pkg::STEP_W-1:0]      remainder,
    output hsp_pkg::div_stat_t              stat
);
    import hsp_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [MAG_W-1:0]  quo_reg;
    logic [MAG_W-1:0]  quo_next;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] rem_next;
    logic [STEP_W-1:0] dsr_reg;
    logic [STEP_W-1:0] dsr_next;
    logic [STEP_W:0]   trial;
    logic [STEP_W:0]   trial_sub;
    logic              fits;

    // one restoring step: next dividend bit into the partial remainder
    assign trial     = {rem_reg, quo_reg[MAG_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(MAG_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[MAG_W-2:0], fits};
            rem_next = fits ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // checks
    `HSP_ASSERT_NOW(a_rem_below_divisor, busy_reg || done_reg, rem_reg < dsr_reg)
    `HSP_ASSERT_NOW(a_busy_not_done, busy_reg, !done_reg)
    `HSP_ASSERT_NEXT(a_start_runs, start, busy_reg && cnt_reg == CNT_W'(MAG_W))

endmodule

[sim/heliostat_step_planner_test.sv]
`timescale 1ns / 100ps

module heliostat_step_planner_test;
    import hsp_pkg::*;

    // fixed point and saturation bounds of the planner
    localparam longint ONE        = longint'(1) << FRAC_BITS;
    localparam longint STEP_TOP   = (longint'(1) << STEPS_W) - 1;
    localparam longint MIRROR_HI  = (longint'(1) << (MIR_W - 1)) - 1;
    localparam longint MIRROR_LO  = -(longint'(1) << (MIR_W - 1));
    localparam longint POSN_HI    = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POSN_LO    = -(longint'(1) << (POS_W - 1));
    localparam int     CYCLE_LIMIT = 1000000;

    // bit offsets of the plan fields in m_tdata
    localparam int OFS_ZUP = STEPS_W;
    localparam int OFS_AST = STEPS_W + 1;
    localparam int OFS_AUP = 2 * STEPS_W + 1;
    localparam int OFS_MZ  = 2 * STEPS_W + 2;
    localparam int OFS_MA  = OFS_MZ + MIR_W;

    typedef struct {
        logic             cmd;
        logic [ZEN_W-1:0] zen;
        logic             neg;
        logic [AZI_W-1:0] azi;
    } sun_sample_t;

    typedef struct {
        logic [STEPS_W-1:0] zen_steps;
        logic               zen_up;
        logic [STEPS_W-1:0] azi_steps;
        logic               azi_up;
        logic [MIR_W-1:0]   mir_zen;
        logic [MIR_W-1:0]   mir_azi;
    } step_plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow registers and motor state of the planner
    logic signed [TGT_W-1:0] tgt_zen;
    logic signed [TGT_W-1:0] tgt_azi;
    logic                    north;
    logic [STEP_W-1:0]       step_sz;
    longint                  zen_pos;
    longint                  azi_pos;
    longint                  last_mir_azi;

    sun_sample_t pending_q[$];
    step_plan_t  plan_q[$];
    sun_sample_t cur_sample;
    int          tx_gap = 0;
    int          rx_stall = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          mismatches = 0;
    int          cycle_cnt = 0;

    heliostat_step_planner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // steps for one motor, moves its position toward the mirror
    function automatic longint drive_motor(input longint mirror, inout longint pos,
                                           input bit below, output bit up);
        longint div;
        longint diff;
        longint mag;
        longint steps;
        div = (step_sz == 0) ? 1 : longint'(step_sz);
        diff = mirror - pos;
        mag = (diff < 0) ? -diff : diff;
        steps = below ? 0 : mag / div;
        if (steps > STEP_TOP)
            steps = STEP_TOP;
        up = (mirror >= pos);
        if (up)
            pos = clamp(pos + steps * div, POSN_LO, POSN_HI);
        else
            pos = clamp(pos - steps * div, POSN_LO, POSN_HI);
        return steps;
    endfunction

    // mirror angles and motor plan for one sun sample
    function automatic step_plan_t plan_sample(input sun_sample_t s);
        step_plan_t p;
        longint z;
        longint a;
        longint tz;
        longint ta;
        longint mz2;
        longint ma2;
        longint mz;
        longint ma;
        longint zs;
        longint as;
        bit hit;
        bit below;
        bit zup;
        bit aup;
        p = '{default: '0};
        if (s.cmd == CMD_HOME)
        begin
            zen_pos = 0;
            azi_pos = -90 * ONE;
            return p;
        end
        below = s.neg;
        z = longint'(s.zen);
        if (below)
            z = -z;
        a = longint'(s.azi);
        tz = tgt_zen;
        ta = tgt_azi;
        ma2 = 0;
        hit = 1'b1;
        if (north)
        begin
            mz2 = z + tz;
            if (a >= 180 && 360 - a >= ta)
                ma2 = 360 + ta - a;
            else if (a > 180 && 360 - a < ta)
                ma2 = 360 + ta - a;
            else if (a < 180 && a < ta)
                ma2 = ta + a;
            else if (a <= 180 && a >= ta)
                ma2 = ta + a;
            else
                hit = 1'b0;
        end
        else
        begin
            mz2 = 180 - z + tz;
            if (a > 180 && ta <= 0)
                ma2 = a + ta - 180;
            else if (a < 180 && ta < 0)
                ma2 = 180 - a - ta;
            else if (a > 180 && ta > 0)
                ma2 = a - ta - 180;
            else if (a < 180 && ta >= 0)
                ma2 = 180 - a + ta;
            else
                hit = 1'b0;
        end
        mz = clamp(mz2 * ONE / 2, MIRROR_LO, MIRROR_HI);
        ma = hit ? clamp(ma2 * ONE / 2, MIRROR_LO, MIRROR_HI) : last_mir_azi;
        last_mir_azi = ma;

        // azimuth wrap correction, applied even below the horizon
        if (ma - azi_pos > 100 * ONE && azi_pos > 0)
            azi_pos = clamp(azi_pos + 180 * ONE, POSN_LO, POSN_HI);

        zs = drive_motor(mz, zen_pos, below, zup);
        as = drive_motor(ma, azi_pos, below, aup);
        p.zen_steps = zs[STEPS_W-1:0];
        p.zen_up    = zup;
        p.azi_steps = as[STEPS_W-1:0];
        p.azi_up    = aup;
        p.mir_zen   = mz[MIR_W-1:0];
        p.mir_azi   = ma[MIR_W-1:0];
        return p;
    endfunction

    // gap length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("plan mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // compare one output beat with the oldest pending plan
    task automatic check_plan(input logic [OUT_TDATA_W-1:0] beat);
        step_plan_t want;
        if (plan_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected plan beat %0h", beat);
        end
        else
        begin
            want = plan_q.pop_front();
            check_field("zenith_steps", 32'(want.zen_steps), 32'(beat[0 +: STEPS_W]));
            check_field("zenith_up", 32'(want.zen_up), 32'(beat[OFS_ZUP]));
            check_field("azimuth_steps", 32'(want.azi_steps), 32'(beat[OFS_AST +: STEPS_W]));
            check_field("azimuth_up", 32'(want.azi_up), 32'(beat[OFS_AUP]));
            check_field("mirror_zenith", 32'(want.mir_zen), 32'(beat[OFS_MZ +: MIR_W]));
            check_field("mirror_azimuth", 32'(want.mir_azi), 32'(beat[OFS_MA +: MIR_W]));
        end
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                plan_q.push_back(plan_sample(cur_sample));
                if (!tx_steady && $urandom_range(0, 99) < 30)
                    tx_gap = idle_len();
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0 || pending_q.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (tx_gap > 0)
                        tx_gap = tx_gap - 1;
                end
                else
                begin
                    cur_sample = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'({cur_sample.azi, cur_sample.neg, cur_sample.zen});
                    s_tuser  <= cur_sample.cmd;
                end
            end
        end
    end

    // plan monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_plan(m_tdata);
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else if (!rx_steady && $urandom_range(0, 99) < 25)
            begin
                m_tready <= 1'b0;
                rx_stall <= idle_len();
            end
            else
                m_tready <= 1'b1;
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TARGET_ZENITH:  tgt_zen = data[TGT_W-1:0];
            REG_TARGET_AZIMUTH: tgt_azi = data[TGT_W-1:0];
            REG_NORTH_MODE:     north = data[0];
            REG_STEP_SIZE:      step_sz = data[STEP_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] tz, input logic [15:0] ta,
                              input logic [15:0] nm, input logic [15:0] st);
        write_reg(REG_TARGET_ZENITH, tz);
        write_reg(REG_TARGET_AZIMUTH, ta);
        write_reg(REG_NORTH_MODE, nm);
        write_reg(REG_STEP_SIZE, st);
    endtask

    task automatic push_sample(input logic cmd, input int zen, input logic neg, input int azi);
        sun_sample_t s;
        s.cmd = cmd;
        s.zen = zen[ZEN_W-1:0];
        s.neg = neg;
        s.azi = azi[AZI_W-1:0];
        pending_q.push_back(s);
    endtask

    // sender pauses here until every plan has come back
    // checked between edges so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || plan_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] pick_target();
        int r;
        logic [TGT_W-1:0] t;
        r = $urandom_range(0, 9);
        case (r)
            0: t = TGT_W'(-512);
            1: t = TGT_W'(511);
            2: t = TGT_W'(-180);
            3: t = TGT_W'(360);
            4: t = '0;
            5, 6: t = TGT_W'($urandom);
            default: t = TGT_W'(-180 + int'($urandom_range(0, 540)));
        endcase
        return {6'($urandom), t};
    endfunction

    function automatic logic [15:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return STEP_RESET;
            4, 5, 6: return 16'($urandom_range(1, 600));
            7: return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed samples, some homes and some full-width noise
    task automatic push_random();
        int r;
        int zen;
        int azi;
        logic neg;
        r = $urandom_range(0, 99);
        if (r < 6)
            push_sample(CMD_HOME, $urandom_range(0, 255), $urandom_range(0, 1),
                        $urandom_range(0, 511));
        else if (r < 14)
            push_sample(CMD_TRACK, $urandom_range(0, 255), $urandom_range(0, 1),
                        $urandom_range(0, 511));
        else
        begin
            zen = $urandom_range(0, 180);
            neg = ($urandom_range(0, 99) < 15);
            case ($urandom_range(0, 9))
                0: azi = 0;
                1: azi = 179 + int'($urandom_range(0, 2));
                2: azi = 360;
                default: azi = $urandom_range(0, 360);
            endcase
            push_sample(CMD_TRACK, zen, neg, azi);
        end
    endtask

    initial
    begin
        int ph;
        int i;

        tgt_zen = '0;
        tgt_azi = '0;
        north = 1'b1;
        step_sz = STEP_RESET;
        zen_pos = 0;
        azi_pos = 0;
        last_mir_azi = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: north, zero targets, default step
        push_sample(CMD_HOME, 0, 1'b0, 0);
        push_sample(CMD_TRACK, 0, 1'b0, 0);
        push_sample(CMD_TRACK, 180, 1'b0, 180);
        push_sample(CMD_TRACK, 255, 1'b0, 511);
        push_sample(CMD_TRACK, 45, 1'b1, 90);
        push_sample(CMD_TRACK, 90, 1'b0, 270);
        push_sample(CMD_TRACK, 10, 1'b0, 360);
        push_sample(CMD_HOME, 255, 1'b1, 511);
        push_sample(CMD_TRACK, 10, 1'b0, 20);
        wait_drained();

        // north with far targets: wrap, no matching case, lower branches
        set_config(16'(-512), 16'(511), 16'd1, 16'd1);
        push_sample(CMD_TRACK, 30, 1'b0, 0);
        push_sample(CMD_TRACK, 60, 1'b0, 180);
        push_sample(CMD_TRACK, 120, 1'b0, 300);
        push_sample(CMD_TRACK, 255, 1'b1, 181);
        wait_drained();

        // south with the opposite extremes, step size zero
        set_config(16'(511), 16'(-512), 16'd0, 16'd0);
        push_sample(CMD_TRACK, 0, 1'b0, 200);
        push_sample(CMD_TRACK, 70, 1'b0, 100);
        push_sample(CMD_TRACK, 50, 1'b0, 180);
        wait_drained();

        // south with a small positive target, widest step
        set_config(16'd0, 16'd5, 16'd0, 16'hFFFF);
        push_sample(CMD_TRACK, 20, 1'b0, 300);
        push_sample(CMD_TRACK, 160, 1'b0, 100);
        push_sample(CMD_TRACK, 90, 1'b1, 180);
        wait_drained();

        // random settings per phase
        for (ph = 0; ph < 8; ph++)
        begin
            set_config(pick_target(), pick_target(), 16'($urandom), pick_step());
            tx_steady = (ph % 3 == 1);
            rx_steady = (ph % 4 == 2);
            for (i = 0; i < 50; i++)
                push_random();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && plan_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
